>>> rtl/cvta_pkg.sv
// Package for the cube-map view texel address unit.
// Holds widths, face offset codes, register indexes, the divider stage record and a helper function.
// No dependencies.
package cvta_pkg;

  localparam int COEF_FRAC_BITS = 16;
  localparam int MAX_FACE_SIZE  = 4096;
  localparam int MAX_VIEW_DIM   = 4096;

  localparam int COEF_W = COEF_FRAC_BITS + 5;
  localparam int CFG_W  = 3 * COEF_W;
  localparam int PIX_W  = 12;
  localparam int FREG_W = 13;
  localparam int FACE_W = 13;
  localparam int PROD_W = COEF_W + PIX_W + 1;
  localparam int VEC_W  = PROD_W + 2;
  localparam int MAG_W  = VEC_W;
  localparam int SUM_W  = MAG_W + 1;
  localparam int K_W    = MAG_W + 4;
  localparam int DIF_W  = VEC_W + 2;
  localparam int DEN_W  = MAG_W + 1;
  localparam int NUM_W  = FACE_W + K_W + 1;
  localparam int QUO_W  = 15;
  localparam int COL_W  = 12;
  localparam int ROW_W  = 15;
  localparam int IDX_W  = 27;
  localparam int LIM_W  = 16;
  localparam int OFS_W  = 3;

  // Face offset codes for the dominant axis.
  localparam logic [OFS_W-1:0] OFS_X = 3'd1;
  localparam logic [OFS_W-1:0] OFS_Y = 3'd3;
  localparam logic [OFS_W-1:0] OFS_Z = 3'd5;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_COEF_X = 2'd0;
  localparam logic [1:0] REG_COEF_Y = 2'd1;
  localparam logic [1:0] REG_COEF_Z = 2'd2;
  localparam logic [1:0] REG_FACE   = 2'd3;

  // One stage of the restoring divider, two lanes sharing one divisor.
  typedef struct packed {
    logic [NUM_W-1:0] rem_c;
    logic [NUM_W-1:0] rem_r;
    logic [QUO_W-1:0] q_c;
    logic [QUO_W-1:0] q_r;
    logic [DEN_W-1:0] den;
    logic             zero;
  } stg_t;

  // Magnitude of a signed direction component.
  function automatic logic [MAG_W-1:0] mag_f(input logic signed [VEC_W-1:0] v);
    logic signed [VEC_W-1:0] n;
    n = -v;
    return v[VEC_W-1] ? MAG_W'(n) : MAG_W'(v);
  endfunction

endpackage

>>> rtl/cvta_divider.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes.
// Depends on cvta_pkg for the stage record and widths.
module cvta_divider import cvta_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  stg_t in_item,
  output logic out_valid,
  input  logic out_ready,
  output stg_t out_item
);

  logic [QUO_W-1:0] v_r;
  logic [QUO_W:0]   v;
  logic [QUO_W:0]   rdy;
  stg_t             st_r [QUO_W];

  assign v[0]       = in_valid;
  assign v[QUO_W:1] = v_r;
  assign rdy[QUO_W] = out_ready;
  assign in_ready   = rdy[0];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stg
    localparam int B = QUO_W - 1 - k;
    stg_t             cur;
    stg_t             nxt;
    logic [NUM_W-1:0] dsh;
    logic             gc;
    logic             gr;

    if (k == 0) begin : g_first
      assign cur = in_item;
    end else begin : g_rest
      assign cur = st_r[k-1];
    end

    // Compare against the shifted divisor and subtract where it fits.
    always_comb begin
      dsh       = NUM_W'(cur.den) << B;
      gc        = cur.rem_c >= dsh;
      gr        = cur.rem_r >= dsh;
      nxt       = cur;
      nxt.rem_c = gc ? cur.rem_c - dsh : cur.rem_c;
      nxt.rem_r = gr ? cur.rem_r - dsh : cur.rem_r;
      nxt.q_c   = {cur.q_c[QUO_W-2:0], gc};
      nxt.q_r   = {cur.q_r[QUO_W-2:0], gr};
    end

    assign rdy[k] = !v_r[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && v[k]) begin
        st_r[k] <= nxt;
      end
    end
  end

  assign out_valid = v[QUO_W];
  assign out_item  = st_r[QUO_W-1];

endmodule

>>> rtl/cubemap_view_texel_address.sv
// Cube-map view texel address unit: pixel position in, texel column, row and index out.
// From input transfer to result the pipeline holds seven front stages (products,
// sums, two axis swaps, operand prep, face-size products, numerator), a 15-stage
// divider with one quotient bit per stage, a clamp stage and the index output register.
// Throughput is one item per cycle; each stage advances whenever the next one is free.
// Reset is synchronous: valid bits clear, coefficients go to zero, face size to 512.
// Depends on cvta_pkg and cvta_divider.
module cubemap_view_texel_address import cvta_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // [11:0] pixel_row, [23:12] pixel_col
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // [11:0] texel_col, [26:12] texel_row, [53:27] texel_index
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  // Configuration registers.
  logic [CFG_W-1:0]  coef_x_r, coef_y_r, coef_z_r;
  logic [FREG_W-1:0] face_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_x_r <= '0;
      coef_y_r <= '0;
      coef_z_r <= '0;
      face_r   <= FREG_W'(512);
    end else if (cfg_wr) begin
      case (cfg_paddr[4:3])
        REG_COEF_X: coef_x_r <= cfg_pwdata[CFG_W-1:0];
        REG_COEF_Y: coef_y_r <= cfg_pwdata[CFG_W-1:0];
        REG_COEF_Z: coef_z_r <= cfg_pwdata[CFG_W-1:0];
        REG_FACE:   face_r   <= cfg_pwdata[FREG_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:3])
      REG_COEF_X: cfg_prdata = 64'(coef_x_r);
      REG_COEF_Y: cfg_prdata = 64'(coef_y_r);
      REG_COEF_Z: cfg_prdata = 64'(coef_z_r);
      REG_FACE:   cfg_prdata = 64'(face_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // Effective face size, saturated.
  logic [FACE_W-1:0] n_sat;
  assign n_sat = (face_r > FREG_W'(MAX_FACE_SIZE)) ? FACE_W'(MAX_FACE_SIZE)
                                                   : FACE_W'(face_r);

  // Stage 1: six coefficient products and the three constant terms.
  logic [PIX_W-1:0]         pr, pc;
  logic signed [PIX_W:0]    prs, pcs;
  logic signed [PROD_W-1:0] s1_p_r [9];
  logic signed [PROD_W-1:0] s1_p_nxt [9];
  logic                     s1_v_r, rdy1;

  always_comb begin
    pr  = (in_tdata[11:0] > PIX_W'(MAX_VIEW_DIM - 1)) ? PIX_W'(MAX_VIEW_DIM - 1)
                                                      : in_tdata[11:0];
    pc  = (in_tdata[23:12] > PIX_W'(MAX_VIEW_DIM - 1)) ? PIX_W'(MAX_VIEW_DIM - 1)
                                                       : in_tdata[23:12];
    prs = $signed({1'b0, pr});
    pcs = $signed({1'b0, pc});
    s1_p_nxt[0] = PROD_W'($signed(coef_x_r[COEF_W-1:0])) * PROD_W'(prs);
    s1_p_nxt[1] = PROD_W'($signed(coef_x_r[2*COEF_W-1:COEF_W])) * PROD_W'(pcs);
    s1_p_nxt[2] = PROD_W'($signed(coef_x_r[3*COEF_W-1:2*COEF_W]));
    s1_p_nxt[3] = PROD_W'($signed(coef_y_r[COEF_W-1:0])) * PROD_W'(prs);
    s1_p_nxt[4] = PROD_W'($signed(coef_y_r[2*COEF_W-1:COEF_W])) * PROD_W'(pcs);
    s1_p_nxt[5] = PROD_W'($signed(coef_y_r[3*COEF_W-1:2*COEF_W]));
    s1_p_nxt[6] = PROD_W'($signed(coef_z_r[COEF_W-1:0])) * PROD_W'(prs);
    s1_p_nxt[7] = PROD_W'($signed(coef_z_r[2*COEF_W-1:COEF_W])) * PROD_W'(pcs);
    s1_p_nxt[8] = PROD_W'($signed(coef_z_r[3*COEF_W-1:2*COEF_W]));
  end

  // Stage 2: direction components and the degenerate flag.
  logic signed [VEC_W-1:0] s2_x_r, s2_y_r, s2_z_r;
  logic signed [VEC_W-1:0] s2_x_nxt, s2_y_nxt, s2_z_nxt;
  logic                    s2_zero_r, s2_v_r, rdy2;

  assign s2_x_nxt = VEC_W'(s1_p_r[0]) + VEC_W'(s1_p_r[1]) + VEC_W'(s1_p_r[2]);
  assign s2_y_nxt = VEC_W'(s1_p_r[3]) + VEC_W'(s1_p_r[4]) + VEC_W'(s1_p_r[5]);
  assign s2_z_nxt = VEC_W'(s1_p_r[6]) + VEC_W'(s1_p_r[7]) + VEC_W'(s1_p_r[8]);

  // Stage 3: first swap, x against y.
  logic signed [VEC_W-1:0] s3_x_r, s3_y_r, s3_z_r;
  logic [OFS_W-1:0]        s3_off_r;
  logic                    s3_zero_r, s3_v_r, rdy3, sw1;

  assign sw1 = mag_f(s2_x_r) < mag_f(s2_y_r);

  // Stage 4: second swap, x against z, and the dominant magnitude.
  logic signed [VEC_W-1:0] s4_x_r, s4_y_r, s4_z_r;
  logic signed [VEC_W-1:0] s4_x_nxt, s4_y_nxt, s4_z_nxt;
  logic [OFS_W-1:0]        s4_off_r, s4_off_nxt;
  logic [MAG_W-1:0]        s4_a_r;
  logic                    s4_zero_r, s4_v_r, rdy4;

  always_comb begin
    s4_x_nxt   = s3_x_r;
    s4_y_nxt   = s3_y_r;
    s4_z_nxt   = s3_z_r;
    s4_off_nxt = s3_off_r;
    if (mag_f(s3_x_r) < mag_f(s3_z_r)) begin
      s4_x_nxt   = s3_z_r;
      s4_off_nxt = OFS_Z;
      if (s3_off_r == OFS_X) begin
        s4_y_nxt = s3_x_r;
        s4_z_nxt = s3_y_r;
      end else begin
        s4_z_nxt = s3_x_r;
      end
    end
  end

  // Stage 5: col operand, scaled offset and z minus x.
  logic [SUM_W-1:0]        s5_s_r;
  logic [K_W-1:0]          s5_k_r, s5_k_nxt;
  logic signed [DIF_W-1:0] s5_d_r;
  logic [MAG_W-1:0]        s5_a_r;
  logic                    s5_zero_r, s5_v_r, rdy5;
  logic [K_W-1:0]          ak;

  always_comb begin
    ak = K_W'(s4_a_r);
    case (s4_off_r)
      OFS_X:   s5_k_nxt = ak << 1;
      OFS_Y:   s5_k_nxt = (ak << 2) + (ak << 1);
      OFS_Z:   s5_k_nxt = (ak << 3) + (ak << 1);
      default: s5_k_nxt = ak << 1;
    endcase
  end

  // Stage 6: products with the face size.
  logic [FACE_W+SUM_W-1:0]          s6_c_r;
  logic [FACE_W+K_W-1:0]            s6_r1_r;
  logic signed [FACE_W+DIF_W:0]     s6_r2_r;
  logic [MAG_W-1:0]                 s6_a_r;
  logic                             s6_zero_r, s6_v_r, rdy6;

  // Stage 7: numerators and divisor, handed to the divider.
  stg_t s7_r;
  logic s7_v_r, rdy7, div_in_ready;

  // Divider output, clamp stage and output register.
  stg_t               div_out;
  logic               div_out_valid;
  logic [COL_W-1:0]   c_col_r;
  logic [ROW_W-1:0]   c_row_r;
  logic               c_v_r, rdy_c;
  logic [FACE_W-1:0]  nm1;
  logic [LIM_W-1:0]   rlim;
  logic [COL_W-1:0]   col_nxt;
  logic [ROW_W-1:0]   row_nxt;
  logic [COL_W-1:0]   o_col_r;
  logic [ROW_W-1:0]   o_row_r;
  logic [IDX_W-1:0]   o_idx_r;
  logic               o_v_r, rdy_o;

  // Stage advance chain.
  assign rdy_o     = !o_v_r || out_tready;
  assign rdy_c     = !c_v_r || rdy_o;
  assign rdy7      = !s7_v_r || div_in_ready;
  assign rdy6      = !s6_v_r || rdy7;
  assign rdy5      = !s5_v_r || rdy6;
  assign rdy4      = !s4_v_r || rdy5;
  assign rdy3      = !s3_v_r || rdy4;
  assign rdy2      = !s2_v_r || rdy3;
  assign rdy1      = !s1_v_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
      c_v_r  <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (rdy1)  s1_v_r <= in_tvalid;
      if (rdy2)  s2_v_r <= s1_v_r;
      if (rdy3)  s3_v_r <= s2_v_r;
      if (rdy4)  s4_v_r <= s3_v_r;
      if (rdy5)  s5_v_r <= s4_v_r;
      if (rdy6)  s6_v_r <= s5_v_r;
      if (rdy7)  s7_v_r <= s6_v_r;
      if (rdy_c) c_v_r  <= div_out_valid;
      if (rdy_o) o_v_r  <= c_v_r;
    end
  end

  // Front payload registers.
  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      s1_p_r <= s1_p_nxt;
    end
    if (rdy2 && s1_v_r) begin
      s2_x_r    <= s2_x_nxt;
      s2_y_r    <= s2_y_nxt;
      s2_z_r    <= s2_z_nxt;
      s2_zero_r <= (n_sat == '0) ||
                   ((s2_x_nxt == '0) && (s2_y_nxt == '0) && (s2_z_nxt == '0));
    end
    if (rdy3 && s2_v_r) begin
      s3_x_r    <= sw1 ? s2_y_r : s2_x_r;
      s3_y_r    <= sw1 ? s2_x_r : s2_y_r;
      s3_z_r    <= s2_z_r;
      s3_off_r  <= sw1 ? OFS_Y : OFS_X;
      s3_zero_r <= s2_zero_r;
    end
    if (rdy4 && s3_v_r) begin
      s4_x_r    <= s4_x_nxt;
      s4_y_r    <= s4_y_nxt;
      s4_z_r    <= s4_z_nxt;
      s4_off_r  <= s4_off_nxt;
      s4_a_r    <= mag_f(s4_x_nxt);
      s4_zero_r <= s3_zero_r;
    end
    if (rdy5 && s4_v_r) begin
      s5_s_r    <= SUM_W'($signed({1'b0, s4_a_r}) + SUM_W'(s4_y_r));
      s5_k_r    <= s5_k_nxt;
      s5_d_r    <= DIF_W'(s4_z_r) - DIF_W'(s4_x_r);
      s5_a_r    <= s4_a_r;
      s5_zero_r <= s4_zero_r;
    end
    if (rdy6 && s5_v_r) begin
      s6_c_r    <= (FACE_W+SUM_W)'(n_sat) * (FACE_W+SUM_W)'(s5_s_r);
      s6_r1_r   <= (FACE_W+K_W)'(n_sat) * (FACE_W+K_W)'(s5_k_r);
      s6_r2_r   <= (FACE_W+DIF_W+1)'($signed({1'b0, n_sat})) * (FACE_W+DIF_W+1)'(s5_d_r);
      s6_a_r    <= s5_a_r;
      s6_zero_r <= s5_zero_r;
    end
    if (rdy7 && s6_v_r) begin
      s7_r.rem_c <= NUM_W'(s6_c_r);
      s7_r.rem_r <= NUM_W'(s6_r1_r) + NUM_W'(s6_r2_r);
      s7_r.q_c   <= '0;
      s7_r.q_r   <= '0;
      s7_r.den   <= {s6_a_r, 1'b0};
      s7_r.zero  <= s6_zero_r;
    end
  end

  cvta_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s7_v_r),
    .in_ready  (div_in_ready),
    .in_item   (s7_r),
    .out_valid (div_out_valid),
    .out_ready (rdy_c),
    .out_item  (div_out)
  );

  // Clamp into the face strip; a degenerate item gives zero.
  always_comb begin
    nm1  = n_sat - FACE_W'(1);
    rlim = LIM_W'(n_sat) * LIM_W'(6) - LIM_W'(1);
    if (div_out.zero) begin
      col_nxt = '0;
      row_nxt = '0;
    end else begin
      col_nxt = (div_out.q_c > QUO_W'(nm1)) ? COL_W'(nm1) : COL_W'(div_out.q_c);
      row_nxt = (LIM_W'(div_out.q_r) > rlim) ? ROW_W'(rlim) : div_out.q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c && div_out_valid) begin
      c_col_r <= col_nxt;
      c_row_r <= row_nxt;
    end
    if (rdy_o && c_v_r) begin
      o_col_r <= c_col_r;
      o_row_r <= c_row_r;
      o_idx_r <= IDX_W'(c_row_r) * IDX_W'(n_sat) + IDX_W'(c_col_r);
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = {2'b00, o_idx_r, o_row_r, o_col_r};

`ifndef NO_ASSERTIONS
  // An empty output register means every stage can take data.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("input stalled with empty output");

  // The texel column stays inside one face.
  a_col_in_face: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (n_sat == '0) || (FACE_W'(o_col_r) < n_sat))
    else $error("texel column beyond face");

  // The texel row stays inside the six-face strip.
  a_row_in_strip: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (n_sat == '0) || (LIM_W'(o_row_r) < LIM_W'(n_sat) * LIM_W'(6)))
    else $error("texel row beyond strip");

  // Nothing is presented right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("result presented after reset");
`endif

endmodule
